### rtl/core/deq_pkg.sv
// deq_pkg: shared types and codes of the circular deque engine
// command codes, internal operation and result word layouts
// no dependencies
package deq_pkg;

	localparam int DataW = 32;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_REAR   = 3'd3;
	localparam logic [2:0] CMD_LIST       = 3'd4;

	typedef enum logic [2:0] {
		OP_PUSH_F,
		OP_PUSH_R,
		OP_POP_F,
		OP_POP_R,
		OP_LIST
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POP,
		BK_LIST
	} bk_state_t;

	typedef struct packed {
		op_t                     op;
		logic signed [DataW-1:0] data;
	} item_t;

	typedef struct packed {
		status_t                 status;
		logic signed [DataW-1:0] data;
		logic                    last;
	} res_t;

endpackage

### rtl/core/deq_fifo.sv
// deq_fifo: two-entry register queue for one packed word
// used between front and back and on the result side
// no dependencies
module deq_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam logic [1:0] Cap = 2'd2;

	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign full    = (cnt_q == Cap);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) wptr_q <= !wptr_q;
			if (do_rd) rptr_q <= !rptr_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

endmodule

### rtl/core/deq_front.sv
// deq_front: input stage that takes words and decodes the command
// unused command codes are dropped here, the rest go to the command queue
// depends on deq_pkg
module deq_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [2:0]            cmd,
	input  logic signed [31:0]    data_in,
	output logic                  q_wr,
	output deq_pkg::item_t        q_item,
	input  logic                  q_full
);
	import deq_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	op_t   op_dec;
	logic  op_ok;

	always_comb begin
		op_ok  = 1'b1;
		op_dec = OP_LIST;
		unique case (cmd)
			CMD_PUSH_FRONT: op_dec = OP_PUSH_F;
			CMD_PUSH_REAR:  op_dec = OP_PUSH_R;
			CMD_POP_FRONT:  op_dec = OP_POP_F;
			CMD_POP_REAR:   op_dec = OP_POP_R;
			CMD_LIST:       op_dec = OP_LIST;
			default:        op_ok  = 1'b0;
		endcase
	end

	assign full   = valid_s1 && q_full;
	assign q_wr   = valid_s1;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push && op_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_s1.op   <= op_dec;
			item_s1.data <= data_in;
		end
	end

endmodule

### rtl/core/deq_back.sv
// deq_back: circular store, head and tail pointers and command sequencer
// one write and one registered read of the store per cycle
// depends on deq_pkg
module deq_back #(
	parameter int DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  deq_pkg::item_t cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output logic           res_push,
	output deq_pkg::res_t  res
);
	import deq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

	logic [DataW-1:0] mem [DEPTH];
	logic [DataW-1:0] rdata_q;

	bk_state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic          empty_q, empty_d;
	logic [AW-1:0] walk_q, walk_d;
	logic [AW-1:0] cnt_q, cnt_d;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          q_full;
	logic          fin;

	function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
		return (i == LastIdx) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
		return (i == '0) ? LastIdx : i - 1'b1;
	endfunction

	assign q_full = !empty_q && (idx_next(tail_q) == head_q);
	assign fin    = (walk_q == tail_q) || (cnt_q == LastIdx);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && !empty_q) begin
					if (cmd.op == OP_POP_F || cmd.op == OP_POP_R) state_d = BK_POP;
					else if (cmd.op == OP_LIST) state_d = BK_LIST;
				end
			end
			BK_POP: begin
				if (!res_full) state_d = BK_IDLE;
			end
			BK_LIST: begin
				if (!res_full && fin) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res.status = ST_OK;
		res.data   = '0;
		res.last   = 1'b1;
		wr_en      = 1'b0;
		wr_addr    = '0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		head_d     = head_q;
		tail_d     = tail_q;
		empty_d    = empty_q;
		walk_d     = walk_q;
		cnt_d      = cnt_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_PUSH_F, OP_PUSH_R: begin
							if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
								if (q_full) begin
									res.status = ST_FULL;
								end else begin
									wr_en = 1'b1;
									if (empty_q) begin
										head_d  = '0;
										tail_d  = '0;
										empty_d = 1'b0;
										wr_addr = '0;
									end else if (cmd.op == OP_PUSH_F) begin
										head_d  = idx_prev(head_q);
										wr_addr = idx_prev(head_q);
									end else begin
										tail_d  = idx_next(tail_q);
										wr_addr = idx_next(tail_q);
									end
								end
							end
						end
						OP_POP_F, OP_POP_R: begin
							if (empty_q) begin
								if (!res_full) begin
									cmd_pop    = 1'b1;
									res_push   = 1'b1;
									res.status = ST_EMPTY;
								end
							end else begin
								cmd_pop = 1'b1;
								rd_en   = 1'b1;
								if (head_q == tail_q) empty_d = 1'b1;
								if (cmd.op == OP_POP_F) begin
									rd_addr = head_q;
									if (head_q != tail_q) head_d = idx_next(head_q);
								end else begin
									rd_addr = tail_q;
									if (head_q != tail_q) tail_d = idx_prev(tail_q);
								end
							end
						end
						OP_LIST: begin
							if (empty_q) begin
								if (!res_full) begin
									cmd_pop    = 1'b1;
									res_push   = 1'b1;
									res.status = ST_EMPTY;
								end
							end else begin
								cmd_pop = 1'b1;
								rd_en   = 1'b1;
								rd_addr = head_q;
								walk_d  = head_q;
								cnt_d   = '0;
							end
						end
						default: ;
					endcase
				end
			end
			BK_POP: begin
				if (!res_full) begin
					res_push = 1'b1;
					res.data = rdata_q;
				end
			end
			BK_LIST: begin
				if (!res_full) begin
					res_push = 1'b1;
					res.data = rdata_q;
					res.last = fin;
					if (!fin) begin
						walk_d  = idx_next(walk_q);
						cnt_d   = cnt_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = idx_next(walk_q);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			walk_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			walk_q  <= walk_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= cmd.data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

endmodule

### rtl/core/circular_deque_engine_top.sv
// circular_deque_engine_top: double-ended queue of DEPTH words in a circular store
// instantiates deq_front, two deq_fifo queues and deq_back; depends on deq_pkg
//
// Words go in on push/full and results come out on empty/pop, both as queues. A word
// is registered in the input stage and then waits in a two-entry command queue for
// the sequencer. Pushes and commands that fail (push when full, pop or list when empty)
// are answered when the sequencer takes them. Pops also pass through BK_POP, because the
// store has one write port and one read port with registered read data. A list returns
// the stored words in order from the front, DEPTH words at most. Results pass through a
// two-entry result queue, so the sequencer keeps going while a result waits to be taken.
module circular_deque_engine_top #(
	parameter int DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] data_in,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [31:0] data_out,
	output logic               last
);
	import deq_pkg::*;

	logic  fq_wr;
	item_t fq_item;
	logic  cq_full;
	logic  cq_empty;
	item_t cq_item;
	logic  cq_rd;
	logic  rq_wr;
	res_t  rq_in;
	logic  rq_full;
	res_t  rq_out;

	deq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.data_in (data_in),
		.q_wr    (fq_wr),
		.q_item  (fq_item),
		.q_full  (cq_full)
	);

	deq_fifo #(.W($bits(item_t))) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_wr),
		.wr_data (fq_item),
		.full    (cq_full),
		.rd_en   (cq_rd),
		.rd_data (cq_item),
		.empty   (cq_empty)
	);

	deq_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cq_empty),
		.cmd       (cq_item),
		.cmd_pop   (cq_rd),
		.res_full  (rq_full),
		.res_push  (rq_wr),
		.res       (rq_in)
	);

	deq_fifo #(.W($bits(res_t))) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_wr),
		.wr_data (rq_in),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_out),
		.empty   (empty)
	);

	assign status   = rq_out.status;
	assign data_out = rq_out.data;
	assign last     = rq_out.last;

endmodule

### rtl/core/deq_chk.sv
// deq_chk: port-level checks of circular_deque_engine_top
// bound to the top level below; depends on deq_pkg
module deq_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic [1:0]         status,
	input logic signed [31:0] data_out,
	input logic               last
);
	import deq_pkg::*;

	// failed commands give one zero word
	a_fail_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (data_out == '0 && last))
		else $error("failed command word not zero or not last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(data_out) && $stable(status) && $stable(last)))
		else $error("waiting result word changed");

	// right after reset no result is queued and the input is not full
	a_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

endmodule

bind circular_deque_engine_top deq_chk u_deq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.status   (status),
	.data_out (data_out),
	.last     (last)
);

### tb/sv/tb_top.sv
// tb_top: self-checking testbench of circular_deque_engine_top (deque of DEPTH words)
// a scoreboard class predicts every result word; tasks drive commands with random idling
// depends on deq_pkg and circular_deque_engine_top
module tb_top;
	import deq_pkg::*;

	localparam int DEPTH = 8;
	localparam int LIMIT_CYCLES = 200000;

	class deque_scoreboard;
		logic signed [31:0] store [DEPTH];
		int front_idx;
		int rear_idx;
		bit vacant;
		res_t due[$];
		int errors;

		function new();
			front_idx = 0;
			rear_idx = 0;
			vacant = 1'b1;
			errors = 0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void queue_word(status_t st, logic signed [31:0] d, logic l);
			res_t r;
			r.status = st;
			r.data = d;
			r.last = l;
			due.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		function void note_cmd(logic [2:0] c, logic signed [31:0] d);
			int slot;
			int n;
			bit fin;
			logic signed [31:0] w;
			case (c)
				CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
					if (!vacant && (rear_idx + 1) % DEPTH == front_idx) begin
						queue_word(ST_FULL, 0, 1'b1);
					end else begin
						if (vacant) begin
							front_idx = 0;
							rear_idx = 0;
							vacant = 1'b0;
							store[0] = d;
						end else if (c == CMD_PUSH_FRONT) begin
							front_idx = (front_idx + DEPTH - 1) % DEPTH;
							store[front_idx] = d;
						end else begin
							rear_idx = (rear_idx + 1) % DEPTH;
							store[rear_idx] = d;
						end
						queue_word(ST_OK, 0, 1'b1);
					end
				end
				CMD_POP_FRONT, CMD_POP_REAR: begin
					if (vacant) begin
						queue_word(ST_EMPTY, 0, 1'b1);
					end else begin
						if (c == CMD_POP_FRONT) begin
							w = store[front_idx];
							if (front_idx == rear_idx)
								vacant = 1'b1;
							else
								front_idx = (front_idx + 1) % DEPTH;
						end else begin
							w = store[rear_idx];
							if (front_idx == rear_idx)
								vacant = 1'b1;
							else
								rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
						end
						queue_word(ST_OK, w, 1'b1);
					end
				end
				CMD_LIST: begin
					if (vacant) begin
						queue_word(ST_EMPTY, 0, 1'b1);
					end else begin
						slot = front_idx;
						fin = 1'b0;
						for (n = 0; n < DEPTH && !fin; n++) begin
							fin = (slot == rear_idx) || (n == DEPTH - 1);
							queue_word(ST_OK, store[slot], fin);
							slot = (slot + 1) % DEPTH;
						end
					end
				end
				default: ;
			endcase
		endfunction

		task check_word(logic [1:0] st, logic signed [31:0] d, logic l);
			res_t e;
			if (due.size() == 0) begin
				report_mismatch("unexpected word", d, 0);
				return;
			end
			e = due.pop_front();
			if (st !== e.status)
				report_mismatch("status", st, e.status);
			if (d !== e.data)
				report_mismatch("data_out", d, e.data);
			if (l !== e.last)
				report_mismatch("last", l, e.last);
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         cmd;
	logic signed [31:0] data_in;
	logic               empty;
	logic               pop;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic               last;

	deque_scoreboard sb = new();
	int rx_hold_cycles;
	bit rx_calm;
	bit tx_calm;
	bit quiet_end;

	circular_deque_engine_top #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.data_in(data_in),
		.empty(empty),
		.pop(pop),
		.status(status),
		.data_out(data_out),
		.last(last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word(status, data_out, last);
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stall bursts, or a long hold-off when requested
	initial begin
		int n;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				pop <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [2:0] c, input logic signed [31:0] d);
		@(negedge clk);
		push <= 1'b1;
		cmd <= c;
		data_in <= d;
		do @(posedge clk); while (full);
		sb.note_cmd(c, d);
	endtask

	task automatic tx_gap(input int n);
		@(negedge clk);
		push <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh0000_0000;
			1: return 32'shffff_ffff;
			2: return 32'sh7fff_ffff;
			3: return 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_cmd(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			pick_cmd = 3'($urandom_range(5, 7));
		else if (r < 17)
			pick_cmd = CMD_LIST;
		else if ($urandom_range(0, 99) < push_pct)
			pick_cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
		else
			pick_cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
	endfunction

	task automatic run_random(input int n);
		int count;
		int k;
		int push_pct;
		logic [2:0] c;
		count = 0;
		k = 0;
		push_pct = 50;
		while (count < n) begin
			if (k % 30 == 0) begin
				push_pct = $urandom_range(15, 85);
				if (!quiet_end) begin
					rx_calm = ($urandom_range(0, 3) == 0);
					tx_calm = ($urandom_range(0, 3) == 0);
				end
			end
			k++;
			c = pick_cmd(push_pct);
			send_word(c, pick_word());
			if (c <= CMD_LIST)
				count++;
			if (!tx_calm && $urandom_range(0, 5) == 0)
				tx_gap($urandom_range(1, 19));
		end
	endtask

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		cmd = CMD_PUSH_FRONT;
		data_in = 0;
		rx_hold_cycles = 0;
		rx_calm = 1'b0;
		tx_calm = 1'b1;
		quiet_end = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// empty queue, single word in and out, unused codes
		send_word(CMD_LIST, 0);
		send_word(CMD_POP_FRONT, 0);
		send_word(CMD_POP_REAR, 0);
		send_word(CMD_PUSH_REAR, 32'sh7fff_ffff);
		send_word(CMD_POP_FRONT, 0);
		send_word(CMD_PUSH_FRONT, 32'sh8000_0000);
		send_word(CMD_POP_REAR, 0);
		send_word(3'd5, 32'sh5555_5555);
		send_word(3'd6, 32'shaaaa_aaaa);
		send_word(3'd7, 32'shffff_ffff);
		// fill to full from both ends, overflow, full list, wrap
		send_word(CMD_PUSH_FRONT, 32'shffff_ffff);
		send_word(CMD_PUSH_REAR, 32'sh0000_0000);
		for (i = 0; i < DEPTH - 2; i++)
			send_word(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_REAR, $urandom);
		send_word(CMD_PUSH_REAR, 32'sh1234_5678);
		send_word(CMD_PUSH_FRONT, 32'sh1234_5678);
		send_word(CMD_LIST, 0);
		send_word(CMD_POP_FRONT, 0);
		send_word(CMD_PUSH_REAR, 32'sh8000_0001);
		send_word(CMD_POP_REAR, 0);
		send_word(CMD_LIST, 0);

		tx_calm = 1'b0;
		run_random(120);

		// receiver holds off while commands keep coming
		rx_hold_cycles = 100;
		for (i = 0; i < 24; i++)
			send_word(pick_cmd(70), pick_word());

		// sender waits for every outstanding word
		tx_gap(1);
		while (sb.pending() != 0) @(posedge clk);

		run_random(80);

		quiet_end = 1'b1;
		rx_calm = 1'b1;
		tx_calm = 1'b1;
		run_random(31);

		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
